@@ rtl/ncsv_pkg.sv @@
`default_nettype none
package ncsv_pkg;

  typedef logic signed [63:0] fx_t;

  localparam fx_t VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = 1;

  typedef enum logic [1:0] {
    REG_RECEPTOR = 2'd0,
    REG_RATE_ONE = 2'd1,
    REG_RATE_TWO = 2'd2,
    REG_RATE_THREE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [62:0] receptor;
    logic [62:0] rate_one;
    logic [62:0] rate_two;
    logic [62:0] rate_three;
  } cfg_t;

  typedef struct packed {
    logic [62:0] t2;
    logic [62:0] nd;
    logic        trivial;
  } item_t;

  typedef enum logic [5:0] {
    S_IDLE, S_M_NK, S_D_Q, S_D_INV, S_D_INN, S_A_INN, S_M_B,
    S_A_B1, S_A_B2, S_A_B3, S_A_B4, S_D_B,
    S_A_C1, S_A_C2, S_A_C3, S_A_C4, S_D_C, S_D_D,
    S_LOOP, S_M_R2, S_M_BR, S_M_R3, S_M_F, S_A_F1, S_M_CR, S_A_F2, S_A_F3,
    S_A_G1, S_A_G2, S_A_G3, S_A_G4, S_A_G5, S_A_G6,
    S_D_STEP, S_A_NR, S_A_DF, S_D_RAT, S_A_CHK, S_M_BOND, S_OUT
  } state_e;

  function automatic logic [63:0] mag_of(input fx_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic fx_t from_mag(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > 64'(VMAX)) ? 64'(VMAX) : m;
    return neg ? -fx_t'(c) : fx_t'(c);
  endfunction

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SMAX) return VMAX;
    if (s < -SMAX) return -VMAX;
    return s[63:0];
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    return sat_add(a, -b);
  endfunction

endpackage
`default_nettype wire

@@ rtl/ncsv_front.sv @@
`default_nettype none
module ncsv_front import ncsv_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [62:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [62:0] ligand_amount_i,
  input  wire logic [62:0] drug_level_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output item_t            item_o,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.receptor   <= '0;
      cfg_q.rate_one   <= 63'(64'd1 << FracBits);
      cfg_q.rate_two   <= '0;
      cfg_q.rate_three <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RECEPTOR:   cfg_q.receptor   <= cfg_data_i;
        REG_RATE_ONE:   cfg_q.rate_one   <= cfg_data_i;
        REG_RATE_TWO:   cfg_q.rate_two   <= cfg_data_i;
        REG_RATE_THREE: cfg_q.rate_three <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o     = q_full_i;
  assign push_o         = in_valid_i && !q_full_i;
  assign item_o.t2      = ligand_amount_i;
  assign item_o.nd      = drug_level_i;
  // no iteration when either divisor of the setup is zero
  assign item_o.trivial = (ligand_amount_i == '0) || (cfg_q.rate_one == '0);
  assign cfg_o          = cfg_q;
endmodule
`default_nettype wire

@@ rtl/ncsv_fifo.sv @@
`default_nettype none
module ncsv_fifo import ncsv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      head_o
);
  item_t               mem_q [QDEPTH];
  logic [QAW-1:0]      wp_q, rp_q;
  logic [QAW:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i && valid_o) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i && valid_o) rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end
endmodule
`default_nettype wire

@@ rtl/ncsv_mul.sv @@
`default_nettype none
module ncsv_mul import ncsv_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire fx_t  a_i,
  input  wire fx_t  b_i,
  output logic      done_o,
  output fx_t       res_o
);
  logic         busy_q, done_q, neg_q, pv_q;
  logic [2:0]   cnt_q;
  logic [1:0]   sh_q;
  logic [63:0]  ua_q, ub_q, prod_q;
  logic [127:0] acc_q;
  logic         sat;

  // four 32x32 partial products, one per cycle, each registered before it is added to the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pv_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pv_q   <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        pv_q  <= (cnt_q < 3'd4);
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= mag_of(a_i);
      ub_q  <= mag_of(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        prod_q <= ua_q[cnt_q[1]*32 +: 32] * ub_q[cnt_q[0]*32 +: 32];
        sh_q   <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (pv_q) acc_q <= acc_q + ({64'd0, prod_q} << {sh_q, 5'd0});
    end
  end

  assign sat    = |acc_q[127:64+FracBits];
  assign done_o = done_q;
  assign res_o  = from_mag(sat ? '1 : acc_q[FracBits+63:FracBits], neg_q);
endmodule
`default_nettype wire

@@ rtl/ncsv_div.sv @@
`default_nettype none
module ncsv_div import ncsv_pkg::*; #(
  parameter int unsigned FracBits = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire fx_t  a_i,
  input  wire fx_t  b_i,
  output logic      done_o,
  output fx_t       res_o
);
  localparam int unsigned BitsPerCycle = 2;
  localparam int unsigned Cycles = 128 / BitsPerCycle;
  localparam int unsigned CntW = $clog2(Cycles);

  logic            busy_q, done_q, neg_q, st_q, st_d;
  logic [CntW-1:0] cnt_q;
  logic [63:0]     ub_q, rem_q, rem_d, quo_q, quo_d;
  logic [127:0]    num_q, num_d;

  // restoring division, two quotient bits per cycle
  always_comb begin
    logic [64:0] t;
    logic        qb;
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    st_d  = st_q;
    for (int i = 0; i < BitsPerCycle; i++) begin
      t     = {rem_d, num_d[127]};
      num_d = {num_d[126:0], 1'b0};
      qb    = (t >= {1'b0, ub_q});
      if (qb) t = t - {1'b0, ub_q};
      st_d  = st_d | quo_d[63];
      quo_d = {quo_d[62:0], qb};
      rem_d = t[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Cycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[63] ^ b_i[63];
      ub_q  <= mag_of(b_i);
      num_q <= {64'd0, mag_of(a_i)} << FracBits;
      rem_q <= '0;
      quo_q <= '0;
      st_q  <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      st_q  <= st_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = from_mag(st_q ? '1 : quo_q, neg_q);
endmodule
`default_nettype wire

@@ rtl/ncsv_back.sv @@
`default_nettype none
module ncsv_back import ncsv_pkg::*; #(
  parameter int unsigned MaxSteps = 20,
  parameter int unsigned FracBits = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_valid_i,
  input  wire item_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output fx_t        bond_count_o,
  output logic [4:0] steps_used_o,
  output logic       fault_o
);
  localparam int unsigned SW = $clog2(MaxSteps + 1);
  localparam fx_t One = fx_t'(64'd1 << FracBits);
  localparam fx_t Tol = fx_t'(((64'd1 << FracBits) + 64'd50000) / 64'd100000);

  state_e        state_q, state_d;
  logic          issued_q, issued_d, out_valid_q, load_out;
  fx_t           t2_q, t2_d, nd_q, nd_d, b_q, b_d, c_q, c_d, d_q, d_d;
  fx_t           qn_q, qn_d, inv_q, inv_d, tmp_q, tmp_d, root_q, root_d;
  fx_t           r2_q, r2_d, br_q, br_d, f_q, f_d, f1_q, f1_d, nr_q, nr_d;
  fx_t           bond_q, bond_d, bond_o_q;
  logic [SW-1:0] steps_q, steps_d;
  logic          fault_q, fault_d, fault_o_q;
  logic [4:0]    steps_o_q;
  logic [SW+4:0] steps_ext;
  logic          uact, udiv, udone, mul_done, div_done, mul_start, div_start;
  fx_t           ua, ub, ures, mul_res, div_res, t1, k1, k2, k3, dtmp;

  assign t1 = fx_t'({1'b0, cfg_i.receptor});
  assign k1 = fx_t'({1'b0, cfg_i.rate_one});
  assign k2 = fx_t'({1'b0, cfg_i.rate_two});
  assign k3 = fx_t'({1'b0, cfg_i.rate_three});

  ncsv_mul #(.FracBits(FracBits)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ua), .b_i(ub),
    .done_o(mul_done), .res_o(mul_res)
  );

  ncsv_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(ua), .b_i(ub),
    .done_o(div_done), .res_o(div_res)
  );

  assign udone = mul_done | div_done;
  assign ures  = div_done ? div_res : mul_res;

  always_comb begin
    state_d = state_q;
    t2_d = t2_q; nd_d = nd_q; b_d = b_q; c_d = c_q; d_d = d_q;
    qn_d = qn_q; inv_d = inv_q; tmp_d = tmp_q; root_d = root_q;
    r2_d = r2_q; br_d = br_q; f_d = f_q; f1_d = f1_q; nr_d = nr_q;
    bond_d = bond_q; steps_d = steps_q; fault_d = fault_q;
    uact = 1'b0; udiv = 1'b0; ua = '0; ub = '0;
    pop_o = 1'b0; load_out = 1'b0;
    dtmp = sat_sub(nr_q, root_q);
    unique case (state_q)
      S_IDLE: if (q_valid_i) begin
        pop_o  = 1'b1;
        t2_d   = fx_t'({1'b0, head_i.t2});
        nd_d   = fx_t'({1'b0, head_i.nd});
        root_d = '0;
        steps_d = '0;
        fault_d = 1'b0;
        if (head_i.trivial) begin
          bond_d  = '0;
          fault_d = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_M_NK;
        end
      end
      S_M_NK: begin
        uact = 1'b1; ua = nd_q; ub = k2;
        if (udone) begin tmp_d = ures; state_d = S_D_Q; end
      end
      S_D_Q: begin
        uact = 1'b1; udiv = 1'b1; ua = tmp_q; ub = k1;
        if (udone) begin qn_d = ures; state_d = S_D_INV; end
      end
      S_D_INV: begin
        uact = 1'b1; udiv = 1'b1; ua = One; ub = k1;
        if (udone) begin inv_d = ures; state_d = S_D_INN; end
      end
      S_D_INN: begin
        uact = 1'b1; udiv = 1'b1; ua = k3; ub = k1;
        if (udone) begin tmp_d = ures; state_d = S_A_INN; end
      end
      S_A_INN: begin
        tmp_d = sat_sub(sat_add(tmp_q, tmp_q), One);
        state_d = S_M_B;
      end
      S_M_B: begin
        uact = 1'b1; ua = qn_q; ub = tmp_q;
        if (udone) begin b_d = ures; state_d = S_A_B1; end
      end
      S_A_B1: begin tmp_d = sat_add(t2_q, t2_q); state_d = S_A_B2; end
      S_A_B2: begin b_d = sat_sub(b_q, tmp_q); state_d = S_A_B3; end
      S_A_B3: begin b_d = sat_sub(b_q, t1); state_d = S_A_B4; end
      S_A_B4: begin b_d = sat_sub(b_q, inv_q); state_d = S_D_B; end
      S_D_B: begin
        uact = 1'b1; udiv = 1'b1; ua = b_q; ub = t2_q;
        if (udone) begin b_d = ures; state_d = S_A_C1; end
      end
      S_A_C1: begin c_d = sat_add(qn_q, inv_q); state_d = S_A_C2; end
      S_A_C2: begin c_d = sat_add(c_q, t2_q); state_d = S_A_C3; end
      S_A_C3: begin tmp_d = sat_add(t1, t1); state_d = S_A_C4; end
      S_A_C4: begin c_d = sat_add(c_q, tmp_q); state_d = S_D_C; end
      S_D_C: begin
        uact = 1'b1; udiv = 1'b1; ua = c_q; ub = t2_q;
        if (udone) begin c_d = ures; state_d = S_D_D; end
      end
      S_D_D: begin
        uact = 1'b1; udiv = 1'b1; ua = t1; ub = t2_q;
        if (udone) begin d_d = -ures; state_d = S_LOOP; end
      end
      S_LOOP: state_d = (steps_q == SW'(MaxSteps)) ? S_M_BOND : S_M_R2;
      S_M_R2: begin
        uact = 1'b1; ua = root_q; ub = root_q;
        if (udone) begin r2_d = ures; state_d = S_M_BR; end
      end
      S_M_BR: begin
        uact = 1'b1; ua = b_q; ub = root_q;
        if (udone) begin br_d = ures; state_d = S_M_R3; end
      end
      S_M_R3: begin
        uact = 1'b1; ua = r2_q; ub = root_q;
        if (udone) begin tmp_d = ures; state_d = S_M_F; end
      end
      S_M_F: begin
        uact = 1'b1; ua = b_q; ub = r2_q;
        if (udone) begin f_d = ures; state_d = S_A_F1; end
      end
      S_A_F1: begin f_d = sat_add(tmp_q, f_q); state_d = S_M_CR; end
      S_M_CR: begin
        uact = 1'b1; ua = c_q; ub = root_q;
        if (udone) begin tmp_d = ures; state_d = S_A_F2; end
      end
      S_A_F2: begin tmp_d = sat_add(tmp_q, d_q); state_d = S_A_F3; end
      S_A_F3: begin f_d = sat_add(f_q, tmp_q); state_d = S_A_G1; end
      S_A_G1: begin f1_d = sat_add(r2_q, r2_q); state_d = S_A_G2; end
      S_A_G2: begin f1_d = sat_add(f1_q, r2_q); state_d = S_A_G3; end
      S_A_G3: begin tmp_d = sat_add(br_q, br_q); state_d = S_A_G4; end
      S_A_G4: begin tmp_d = sat_add(tmp_q, c_q); state_d = S_A_G5; end
      S_A_G5: begin f1_d = sat_add(f1_q, tmp_q); state_d = S_A_G6; end
      S_A_G6: begin
        if (f1_q == '0) begin
          fault_d = 1'b1;
          state_d = S_M_BOND;
        end else begin
          state_d = S_D_STEP;
        end
      end
      S_D_STEP: begin
        uact = 1'b1; udiv = 1'b1; ua = f_q; ub = f1_q;
        if (udone) begin tmp_d = ures; state_d = S_A_NR; end
      end
      S_A_NR: begin
        nr_d = sat_sub(root_q, tmp_q);
        if (nr_d == '0) begin
          fault_d = 1'b1;
          state_d = S_M_BOND;
        end else begin
          state_d = S_A_DF;
        end
      end
      S_A_DF: begin
        tmp_d = dtmp[63] ? -dtmp : dtmp;
        state_d = S_D_RAT;
      end
      S_D_RAT: begin
        uact = 1'b1; udiv = 1'b1; ua = tmp_q; ub = nr_q;
        if (udone) begin tmp_d = ures; state_d = S_A_CHK; end
      end
      S_A_CHK: begin
        if (tmp_q > Tol) begin
          steps_d = steps_q + 1'b1;
          root_d  = nr_q;
          state_d = S_LOOP;
        end else begin
          state_d = S_M_BOND;
        end
      end
      S_M_BOND: begin
        uact = 1'b1; ua = t2_q; ub = root_q;
        if (udone) begin bond_d = ures; state_d = S_OUT; end
      end
      S_OUT: if (!out_valid_q || !out_stall_i) begin
        load_out = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    mul_start = uact && !udiv && !issued_q;
    div_start = uact && udiv && !issued_q;
    issued_d  = uact && !udone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign steps_ext = {5'd0, steps_q};

  always_ff @(posedge clk_i) begin
    t2_q <= t2_d; nd_q <= nd_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    qn_q <= qn_d; inv_q <= inv_d; tmp_q <= tmp_d; root_q <= root_d;
    r2_q <= r2_d; br_q <= br_d; f_q <= f_d; f1_q <= f1_d; nr_q <= nr_d;
    bond_q <= bond_d; steps_q <= steps_d; fault_q <= fault_d;
    if (load_out) begin
      bond_o_q  <= bond_q;
      steps_o_q <= steps_ext[4:0];
      fault_o_q <= fault_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bond_count_o = bond_o_q;
  assign steps_used_o = steps_o_q;
  assign fault_o      = fault_o_q;
endmodule
`default_nettype wire

@@ rtl/cubic_binding_newton_solver_core.sv @@
// Receptor-ligand bond solver. Each beat of ligand amount and drug level
// (Q32.32) yields one beat with bond count, Newton steps used and a fault
// flag. Items queue in a two-entry buffer ahead of a single sequencer that
// shares one multiplier (four 32x32 partial products) and one radix-4
// divider. An item with zero ligand or zero rate_one skips setup and the
// Newton steps; otherwise setup is followed by up to 20 Newton steps.
// Results wait in an output register while the next item is taken in.
// Write configuration only while the block is idle.
`default_nettype none
module cubic_binding_newton_solver_core import ncsv_pkg::*; #(
  parameter int unsigned MAX_STEPS = 20,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [62:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [62:0] ligand_amount_i,
  input  wire logic [62:0] drug_level_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      bond_count_o,
  output logic [4:0]       steps_used_o,
  output logic             fault_o
);
  logic  q_full, push, pop, q_valid;
  item_t item, head;
  cfg_t  cfg;
  fx_t   bond;

  ncsv_front #(.FracBits(FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .ligand_amount_i, .drug_level_i,
    .q_full_i(q_full), .push_o(push), .item_o(item), .cfg_o(cfg)
  );

  ncsv_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(item), .full_o(q_full),
    .pop_i(pop), .valid_o(q_valid), .head_o(head)
  );

  ncsv_back #(.MaxSteps(MAX_STEPS), .FracBits(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_valid_i(q_valid), .head_i(head),
    .pop_o(pop), .out_valid_o, .out_stall_i, .bond_count_o(bond),
    .steps_used_o, .fault_o
  );

  assign bond_count_o = 64'(bond);
endmodule
`default_nettype wire

@@ rtl/ncsv_chk.sv @@
`default_nettype none
module ncsv_chk #(
  parameter int unsigned MAX_STEPS = 20
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] bond_count_o,
  input wire logic [4:0]  steps_used_o
);
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_bond_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(bond_count_o))
    else $error("stalled bond changed");

  a_steps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_STEPS < 32) |-> steps_used_o <= 5'(MAX_STEPS))
    else $error("too many steps");

  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (MAX_STEPS < 32) && steps_used_o == 5'd0 |-> bond_count_o == 64'd0)
    else $error("nonzero bond with no accepted step");
endmodule

bind cubic_binding_newton_solver_core ncsv_chk #(.MAX_STEPS(MAX_STEPS)) u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .bond_count_o(bond_count_o),
  .steps_used_o(steps_used_o)
);
`default_nettype wire
